FILE: design/guf_pkg.sv
// Shared types and constants for the grid edge union-find block.
// Used by guf_front, guf_back and grid_edge_union_find; depends on nothing.
package guf_pkg;

  localparam int EDGE_W    = 10;  // edge number width
  localparam int COORD_W   = 5;   // reported cell column / row width
  localparam int CFG_W     = 6;   // configuration register width
  localparam int TDATA_I_W = 16;  // input stream data width
  localparam int TDATA_O_W = 16;  // output stream data width

  // Input command codes
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  // Edge directions
  localparam logic DIR_DOWN  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Class of a queued job
  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_BAD,
    KIND_EDGE
  } kind_e;

  // Classified job passed from the front to the back through the queue
  typedef struct packed {
    kind_e              kind;
    logic               dir;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
  } job_t;

  // One result transaction
  typedef struct packed {
    logic               bad_edge;
    logic               edge_direction;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_x;
    logic               carved;
  } result_t;

endpackage

FILE: design/guf_queue.sv
// Two-entry job queue between the front and the back of the union-find block.
// Generic payload width; no package dependency.
module guf_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   fill_q;
  logic         do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop)      fill_q <= fill_q + 2'd1;
      else if (do_pop && !do_push) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= push_data_i;
  end

endmodule

FILE: design/guf_front.sv
// Front end of the union-find block: accept, range-check and decode edges.
// Depends on guf_pkg; feeds guf_queue.
module guf_front #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32,
  parameter int AW         = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        enable_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_command_i,
  input  logic                        in_direction_i,
  input  logic [guf_pkg::EDGE_W-1:0]  in_edge_i,
  input  logic [guf_pkg::CFG_W-1:0]   grid_width_i,
  input  logic [guf_pkg::CFG_W-1:0]   grid_height_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output guf_pkg::job_t               job_o,
  output logic [AW-1:0]               cell_a_o,
  output logic [AW-1:0]               cell_b_o
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int EW  = guf_pkg::EDGE_W;
  localparam int CW  = (WW + HW > EW) ? WW + HW : EW;
  localparam int SW  = ((AW > EW) ? AW : EW) + 1;
  localparam int STW = $clog2(EW);

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHECK,
    F_DIV,
    F_FORM,
    F_PUSH
  } fstate_e;

  fstate_e           state_q;
  logic              cmd_q, dir_q;
  logic [EW-1:0]     edge_q, dvd_q, quot_q;
  logic [WW-1:0]     w_q, div_q, rem_q;
  logic [HW-1:0]     h_q;
  logic [STW-1:0]    step_q;
  guf_pkg::job_t     job_q;
  logic [AW-1:0]     cell_a_q, cell_b_q;

  logic [WW-1:0]     w_eff;
  logic [HW-1:0]     h_eff;
  logic [HW-1:0]     mul_r;
  logic [CW-1:0]     count;
  logic              bad;
  logic [WW:0]       rem_sh, rem_diff;
  logic              ge;
  logic [WW-1:0]     rem_d;
  logic [SW-1:0]     a_sum, b_sum;

  // Saturate the stored geometry to the supported range
  always_comb begin
    if (grid_width_i < 6'd2)               w_eff = WW'(2);
    else if (32'(grid_width_i) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else                                    w_eff = WW'(grid_width_i);
    if (grid_height_i < 6'd1)                h_eff = HW'(1);
    else if (32'(grid_height_i) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else                                      h_eff = HW'(grid_height_i);
  end

  // Edge count for the direction; div_q already holds width or width minus one
  assign mul_r = (dir_q == guf_pkg::DIR_RIGHT) ? h_q : h_q - HW'(1);
  assign count = CW'(div_q) * CW'(mul_r);
  assign bad   = CW'(edge_q) >= count;

  // One restoring divide step per cycle
  assign rem_sh   = {rem_q, dvd_q[EW-1]};
  assign rem_diff = rem_sh - {1'b0, div_q};
  assign ge       = rem_sh >= {1'b0, div_q};
  assign rem_d    = ge ? rem_diff[WW-1:0] : rem_sh[WW-1:0];

  // Upper/left cell: y*w + x, which is the edge number plus y for right edges
  assign a_sum = SW'(edge_q) + ((dir_q == guf_pkg::DIR_RIGHT) ? SW'(quot_q) : SW'(0));
  assign b_sum = a_sum + ((dir_q == guf_pkg::DIR_RIGHT) ? SW'(1) : SW'(w_q));

  assign in_ready_o   = (state_q == F_IDLE) && enable_i;
  assign push_valid_o = (state_q == F_PUSH);
  assign job_o        = job_q;
  assign cell_a_o     = cell_a_q;
  assign cell_b_o     = cell_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      cmd_q    <= guf_pkg::CMD_CLEAR;
      dir_q    <= guf_pkg::DIR_DOWN;
      edge_q   <= '0;
      dvd_q    <= '0;
      quot_q   <= '0;
      w_q      <= '0;
      div_q    <= '0;
      rem_q    <= '0;
      h_q      <= '0;
      step_q   <= '0;
      job_q    <= '0;
      cell_a_q <= '0;
      cell_b_q <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            cmd_q  <= in_command_i;
            dir_q  <= in_direction_i;
            edge_q <= in_edge_i;
            w_q    <= w_eff;
            h_q    <= h_eff;
            div_q  <= (in_direction_i == guf_pkg::DIR_RIGHT) ? w_eff - WW'(1) : w_eff;
            state_q <= F_CHECK;
          end
        end
        F_CHECK: begin
          if (cmd_q == guf_pkg::CMD_CLEAR) begin
            job_q   <= '{kind: guf_pkg::KIND_CLEAR, dir: guf_pkg::DIR_DOWN,
                         cell_x: '0, cell_y: '0};
            state_q <= F_PUSH;
          end else if (bad) begin
            job_q   <= '{kind: guf_pkg::KIND_BAD, dir: dir_q, cell_x: '0, cell_y: '0};
            state_q <= F_PUSH;
          end else begin
            rem_q   <= '0;
            quot_q  <= '0;
            dvd_q   <= edge_q;
            step_q  <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          rem_q  <= rem_d;
          quot_q <= {quot_q[EW-2:0], ge};
          dvd_q  <= {dvd_q[EW-2:0], 1'b0};
          step_q <= step_q + STW'(1);
          if (step_q == STW'(EW - 1)) state_q <= F_FORM;
        end
        F_FORM: begin
          job_q    <= '{kind: guf_pkg::KIND_EDGE, dir: dir_q,
                        cell_x: guf_pkg::COORD_W'(rem_q),
                        cell_y: guf_pkg::COORD_W'(quot_q)};
          cell_a_q <= a_sum[AW-1:0];
          cell_b_q <= b_sum[AW-1:0];
          state_q  <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: design/guf_back.sv
// Back end of the union-find block: parent memory, root searches with path
// compression, linking and the result register. Depends on guf_pkg.
module guf_back #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             init_done_o,
  input  logic             job_valid_i,
  output logic             job_ready_o,
  input  guf_pkg::job_t    job_i,
  input  logic [AW-1:0]    cell_a_i,
  input  logic [AW-1:0]    cell_b_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output guf_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_RD1,
    B_WALK1,
    B_RD2,
    B_WALK2,
    B_LINK,
    B_DONE
  } bstate_e;

  logic [AW-1:0] parent_mem [DEPTH];
  logic [AW-1:0] rd_data_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr, wr_data;

  bstate_e          state_q;
  logic [AW-1:0]    clr_cnt_q, cur_q, start_q, root_q, root_a_q, cell_b_q;
  logic             clr_res_q, init_done_q, second_q, res_valid_q;
  guf_pkg::result_t pend_q, res_q;

  assign init_done_o = init_done_q;
  assign job_ready_o = (state_q == B_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_q;
    wr_en   = 1'b0;
    wr_addr = cur_q;
    wr_data = root_q;
    case (state_q)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = clr_cnt_q;
      end
      B_RD1, B_RD2: rd_en = 1'b1;
      B_WALK1: begin
        rd_en   = (rd_data_q != cur_q);
        rd_addr = rd_data_q;
      end
      B_WALK2: begin
        wr_en   = 1'b1;
        rd_en   = (rd_data_q != root_q);
        rd_addr = rd_data_q;
      end
      B_LINK: begin
        wr_en   = (root_a_q != root_q);
        wr_addr = root_a_q;
        wr_data = root_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) parent_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= parent_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_cnt_q   <= '0;
      clr_res_q   <= 1'b0;
      init_done_q <= 1'b0;
      second_q    <= 1'b0;
      cur_q       <= '0;
      start_q     <= '0;
      root_q      <= '0;
      root_a_q    <= '0;
      cell_b_q    <= '0;
      pend_q      <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_valid_q && res_ready_i && state_q != B_DONE) res_valid_q <= 1'b0;
      case (state_q)
        B_CLEAR: begin
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            clr_cnt_q   <= '0;
            init_done_q <= 1'b1;
            clr_res_q   <= 1'b0;
            pend_q      <= '0;
            state_q     <= clr_res_q ? B_DONE : B_IDLE;
          end else begin
            clr_cnt_q <= clr_cnt_q + AW'(1);
          end
        end
        B_IDLE: begin
          if (job_valid_i) begin
            case (job_i.kind)
              guf_pkg::KIND_CLEAR: begin
                pend_q    <= '0;
                clr_res_q <= 1'b1;
                state_q   <= B_CLEAR;
              end
              guf_pkg::KIND_BAD: begin
                pend_q  <= '{bad_edge: 1'b1, edge_direction: job_i.dir,
                             cell_y: '0, cell_x: '0, carved: 1'b0};
                state_q <= B_DONE;
              end
              guf_pkg::KIND_EDGE: begin
                pend_q   <= '{bad_edge: 1'b0, edge_direction: job_i.dir,
                              cell_y: job_i.cell_y, cell_x: job_i.cell_x,
                              carved: 1'b0};
                cur_q    <= cell_a_i;
                start_q  <= cell_a_i;
                cell_b_q <= cell_b_i;
                second_q <= 1'b0;
                state_q  <= B_RD1;
              end
              default: begin
                pend_q  <= '0;
                state_q <= B_IDLE;
              end
            endcase
          end
        end
        B_RD1: state_q <= B_WALK1;
        B_WALK1: begin
          if (rd_data_q == cur_q) begin
            root_q <= cur_q;
            if (cur_q != start_q) begin
              // compress the path from the start cell
              cur_q   <= start_q;
              state_q <= B_RD2;
            end else if (!second_q) begin
              root_a_q <= cur_q;
              second_q <= 1'b1;
              cur_q    <= cell_b_q;
              start_q  <= cell_b_q;
              state_q  <= B_RD1;
            end else begin
              state_q <= B_LINK;
            end
          end else begin
            cur_q <= rd_data_q;
          end
        end
        B_RD2: state_q <= B_WALK2;
        B_WALK2: begin
          if (rd_data_q == root_q) begin
            if (!second_q) begin
              root_a_q <= root_q;
              second_q <= 1'b1;
              cur_q    <= cell_b_q;
              start_q  <= cell_b_q;
              state_q  <= B_RD1;
            end else begin
              state_q <= B_LINK;
            end
          end else begin
            cur_q <= rd_data_q;
          end
        end
        B_LINK: begin
          pend_q.carved <= (root_a_q != root_q);
          state_q       <= B_DONE;
        end
        B_DONE: begin
          if (!res_valid_q || res_ready_i) begin
            res_q       <= pend_q;
            res_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: design/grid_edge_union_find.sv
// Top level of the grid edge union-find block for maze carving.
// Depends on guf_pkg, guf_front, guf_queue and guf_back.
//
// Disjoint-set forest over the cells of a grid of up to MAX_WIDTH by
// MAX_HEIGHT cells, cell (x, y) at index y * width + x. A clear transaction
// (tuser low) resets every cell to its own parent and returns one all-zero
// result. An edge transaction decodes its number into the upper or left
// cell of a down or right edge, finds both roots with full path compression,
// and returns carved high (linking the first root under the second) when they
// differ; numbers past the edge count return bad_edge and leave the forest
// alone. Width and height registers are stored as written and used saturated
// to 2..MAX_WIDTH and 1..MAX_HEIGHT; write them only while the block is idle.
// Operation: the front takes one item at a time (accept, range check with
// one multiply, a ten-step restoring divide, cell forming, queue push). The
// back walks each root search one node at a time, then points every node on
// the path at the root, with a read set-up state before each walk, and job
// hand-over, link and result around them; its one read a cycle from the
// parent memory sets its pace. A clear sweeps all MAX_WIDTH * MAX_HEIGHT
// parent memory entries (1024 at the defaults), one entry a cycle; the same
// sweep runs after reset, during which no item is accepted. A two-entry
// queue lets the front decode the next edge while the back works.
module grid_edge_union_find #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [guf_pkg::CFG_W-1:0]       cfg_data_i,
  // command stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [0] direction, [10:1] edge_number, [15:11] zero
  input  logic [guf_pkg::TDATA_I_W-1:0]   s_axis_tdata,
  // [0] command
  input  logic                            s_axis_tuser,
  // result stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] carved, [5:1] cell_x, [10:6] cell_y, [11] edge_direction,
  // [12] bad_edge, [15:13] zero
  output logic [guf_pkg::TDATA_O_W-1:0]   m_axis_tdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = $bits(guf_pkg::job_t) + 2 * AW;
  localparam int RW    = $bits(guf_pkg::result_t);

  logic [guf_pkg::CFG_W-1:0] width_q, height_q;

  logic             init_done;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  guf_pkg::job_t    push_job, pop_job;
  logic [AW-1:0]    push_a, push_b, pop_a, pop_b;
  logic [QW-1:0]    push_data, pop_data;
  guf_pkg::result_t res;

  // Configuration registers: always ready, hold the raw written value
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 6'd32;
      height_q <= 6'd32;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == guf_pkg::REG_WIDTH) width_q  <= cfg_data_i;
      else                                   height_q <= cfg_data_i;
    end
  end

  // Accept and classify
  guf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .enable_i       (init_done),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_command_i   (s_axis_tuser),
    .in_direction_i (s_axis_tdata[0]),
    .in_edge_i      (s_axis_tdata[guf_pkg::EDGE_W:1]),
    .grid_width_i   (width_q),
    .grid_height_i  (height_q),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .job_o          (push_job),
    .cell_a_o       (push_a),
    .cell_b_o       (push_b)
  );

  // Decouple front from back
  assign push_data = {push_job, push_a, push_b};
  assign {pop_job, pop_a, pop_b} = pop_data;

  guf_queue #(
    .W (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Search, compress, link and report
  guf_back #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .init_done_o (init_done),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .cell_a_i    (pop_a),
    .cell_b_i    (pop_b),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pad the result up to whole bytes
  assign m_axis_tdata = {{(guf_pkg::TDATA_O_W - RW){1'b0}}, res};

endmodule
